/* hdl/wmt_pkg.sv */
// Package for the windowed minimum tracker.
// Holds the fixed constants shared by the slot logic and the top level.
// Depends on nothing.
package wmt_pkg;

    // Number of tracked slots: best, second best, third best.
    localparam int SLOT_COUNT = 3;

    // Slot positions.
    localparam int SLOT_BEST   = 0;
    localparam int SLOT_SECOND = 1;
    localparam int SLOT_THIRD  = 2;

    // Width and reset value of the window length register.
    localparam int WINDOW_BITS = 32;
    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 32'd10000000;

    // Refresh limits are the window divided by four and by two.
    localparam int QUARTER_SHIFT = 2;
    localparam int HALF_SHIFT    = 1;

endpackage

/* hdl/wmt_stream_if.sv */
// Stream interfaces for the windowed minimum tracker.
// wmt_sample_if carries delay samples in; wmt_result_if carries the best slot out.
// Depends on nothing.
interface wmt_sample_if #(
    parameter int VALUE_BITS = 24,
    parameter int TIME_BITS  = 48
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] sample_value;
    logic [TIME_BITS-1:0]  sample_time;

    modport source (output valid, output sample_value, output sample_time, input ready);
    modport sink   (input valid, input sample_value, input sample_time, output ready);
endinterface

interface wmt_result_if #(
    parameter int VALUE_BITS = 24,
    parameter int TIME_BITS  = 48
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] best_value;
    logic [TIME_BITS-1:0]  best_time;

    modport source (output valid, output best_value, output best_time, input ready);
    modport sink   (input valid, input best_value, input best_time, output ready);
endinterface

/* hdl/wmt_slots.sv */
// Three-slot windowed minimum state and its combinational update, registered on load.
// Uses wmt_pkg for slot positions, window width and refresh shifts.
module wmt_slots #(
    parameter int VALUE_BITS = 24,
    parameter int TIME_BITS  = 48
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             load,
    input  logic [VALUE_BITS-1:0]            sample_value,
    input  logic [TIME_BITS-1:0]             sample_time,
    input  logic [wmt_pkg::WINDOW_BITS-1:0]  window_length,
    output logic [VALUE_BITS-1:0]            best_value,
    output logic [TIME_BITS-1:0]             best_time
);

    logic [VALUE_BITS-1:0] val_reg  [wmt_pkg::SLOT_COUNT];
    logic [TIME_BITS-1:0]  time_reg [wmt_pkg::SLOT_COUNT];
    logic [VALUE_BITS-1:0] val_next [wmt_pkg::SLOT_COUNT];
    logic [TIME_BITS-1:0]  time_next[wmt_pkg::SLOT_COUNT];
    logic                  have_reg;

    logic [VALUE_BITS-1:0] p1_value, p2_value;
    logic [TIME_BITS-1:0]  p1_time, p2_time;
    logic                  do_fill, ins_second, ins_third;
    logic                  best_expired, second_expired, quarter_hit, half_hit;

    // Modular compare: a <= b when a - b is zero or negative.
    function automatic logic val_le(input logic [VALUE_BITS-1:0] a,
                                    input logic [VALUE_BITS-1:0] b);
        logic [VALUE_BITS-1:0] diff;
        begin
            diff = a - b;
            return (diff == '0) || diff[VALUE_BITS-1];
        end
    endfunction

    // A slot is expired when the wrapped age exceeds the limit.
    function automatic logic is_expired(input logic [TIME_BITS-1:0] now,
                                        input logic [TIME_BITS-1:0] then_time,
                                        input logic [wmt_pkg::WINDOW_BITS-1:0] limit);
        logic [TIME_BITS-1:0] age;
        begin
            age = now - then_time;
            return age > TIME_BITS'(limit);
        end
    endfunction

    // Fill decision and insertion into the second and third slots.
    always_comb
    begin
        do_fill    = !have_reg
                   || val_le(sample_value, val_reg[wmt_pkg::SLOT_BEST])
                   || is_expired(sample_time, time_reg[wmt_pkg::SLOT_THIRD], window_length);
        ins_second = val_le(sample_value, val_reg[wmt_pkg::SLOT_SECOND]);
        ins_third  = ins_second || val_le(sample_value, val_reg[wmt_pkg::SLOT_THIRD]);
        p1_value   = ins_second ? sample_value : val_reg[wmt_pkg::SLOT_SECOND];
        p1_time    = ins_second ? sample_time  : time_reg[wmt_pkg::SLOT_SECOND];
        p2_value   = ins_third  ? sample_value : val_reg[wmt_pkg::SLOT_THIRD];
        p2_time    = ins_third  ? sample_time  : time_reg[wmt_pkg::SLOT_THIRD];
    end

    // Expiry and refresh conditions on the slots after insertion.
    always_comb
    begin
        best_expired   = is_expired(sample_time, time_reg[wmt_pkg::SLOT_BEST], window_length);
        second_expired = is_expired(sample_time, p1_time, window_length);
        quarter_hit    = (p1_value == val_reg[wmt_pkg::SLOT_BEST])
                       && is_expired(sample_time, p1_time,
                                     window_length >> wmt_pkg::QUARTER_SHIFT);
        half_hit       = (p2_value == p1_value)
                       && is_expired(sample_time, p2_time,
                                     window_length >> wmt_pkg::HALF_SHIFT);
    end

    // Next slot contents, in priority order of the update rules.
    always_comb
    begin
        val_next[wmt_pkg::SLOT_BEST]    = val_reg[wmt_pkg::SLOT_BEST];
        time_next[wmt_pkg::SLOT_BEST]   = time_reg[wmt_pkg::SLOT_BEST];
        val_next[wmt_pkg::SLOT_SECOND]  = p1_value;
        time_next[wmt_pkg::SLOT_SECOND] = p1_time;
        val_next[wmt_pkg::SLOT_THIRD]   = p2_value;
        time_next[wmt_pkg::SLOT_THIRD]  = p2_time;
        if (do_fill)
        begin
            for (int i = 0; i < wmt_pkg::SLOT_COUNT; i++)
            begin
                val_next[i]  = sample_value;
                time_next[i] = sample_time;
            end
        end
        else if (best_expired)
        begin
            if (second_expired)
            begin
                val_next[wmt_pkg::SLOT_BEST]    = p2_value;
                time_next[wmt_pkg::SLOT_BEST]   = p2_time;
                val_next[wmt_pkg::SLOT_SECOND]  = sample_value;
                time_next[wmt_pkg::SLOT_SECOND] = sample_time;
            end
            else
            begin
                val_next[wmt_pkg::SLOT_BEST]    = p1_value;
                time_next[wmt_pkg::SLOT_BEST]   = p1_time;
                val_next[wmt_pkg::SLOT_SECOND]  = p2_value;
                time_next[wmt_pkg::SLOT_SECOND] = p2_time;
            end
            val_next[wmt_pkg::SLOT_THIRD]  = sample_value;
            time_next[wmt_pkg::SLOT_THIRD] = sample_time;
        end
        else if (quarter_hit)
        begin
            val_next[wmt_pkg::SLOT_SECOND]  = sample_value;
            time_next[wmt_pkg::SLOT_SECOND] = sample_time;
            val_next[wmt_pkg::SLOT_THIRD]   = sample_value;
            time_next[wmt_pkg::SLOT_THIRD]  = sample_time;
        end
        else if (half_hit)
        begin
            val_next[wmt_pkg::SLOT_THIRD]  = sample_value;
            time_next[wmt_pkg::SLOT_THIRD] = sample_time;
        end
    end

    // Slot registers update once per processed sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
            for (int i = 0; i < wmt_pkg::SLOT_COUNT; i++)
            begin
                val_reg[i]  <= '0;
                time_reg[i] <= '0;
            end
        end
        else if (load)
        begin
            have_reg <= 1'b1;
            for (int i = 0; i < wmt_pkg::SLOT_COUNT; i++)
            begin
                val_reg[i]  <= val_next[i];
                time_reg[i] <= time_next[i];
            end
        end
    end

    assign best_value = val_reg[wmt_pkg::SLOT_BEST];
    assign best_time  = time_reg[wmt_pkg::SLOT_BEST];

endmodule

/* hdl/windowed_min_tracker.sv */
// Windowed minimum tracker: keeps the three best delay samples of a sliding
// time window and reports the best one after every sample. A sample is taken
// into an input register; one pass of compare and select logic then updates
// the three slots once the result register is empty or being drained, and
// the best slot register is the result register. One sample is accepted per
// cycle while results are taken. A result is shown once the slots update and
// can leave at the next clock edge. While a result waits, one more sample can
// be held in the input register; then the input stalls until it transfers.
// Depends on wmt_pkg, wmt_stream_if.sv and wmt_slots.
module windowed_min_tracker #(
    parameter int VALUE_BITS = 24,
    parameter int TIME_BITS  = 48
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [wmt_pkg::WINDOW_BITS-1:0] cfg_wr_data,
    wmt_sample_if.sink                      sample,
    wmt_result_if.source                    result
);

    logic [wmt_pkg::WINDOW_BITS-1:0] window_reg;
    logic                            stage_valid_reg;
    logic [VALUE_BITS-1:0]           stage_value_reg;
    logic [TIME_BITS-1:0]            stage_time_reg;
    logic                            out_valid_reg;
    logic                            advance;
    logic                            load;

    // Window length register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= wmt_pkg::WINDOW_RESET;
        end
        else if (cfg_wr_en)
        begin
            window_reg <= cfg_wr_data;
        end
    end

    // The slot stage moves when the result register is empty or being drained.
    assign advance      = !out_valid_reg || result.ready;
    assign load         = stage_valid_reg && advance;
    assign sample.ready = !stage_valid_reg || advance;

    // Input register takes a sample on each transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            stage_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.ready && sample.valid)
        begin
            stage_value_reg <= sample.sample_value;
            stage_time_reg  <= sample.sample_time;
        end
    end

    // Result valid follows each slot update until the transfer out.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    wmt_slots #(
        .VALUE_BITS (VALUE_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_slots (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .sample_value  (stage_value_reg),
        .sample_time   (stage_time_reg),
        .window_length (window_reg),
        .best_value    (result.best_value),
        .best_time     (result.best_time)
    );

    assign result.valid = out_valid_reg;

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for windowed_min_tracker: directed and random delay samples
// over several window lengths, with random stalls on both stream sides.
// Depends on wmt_pkg, wmt_stream_if.sv and the windowed_min_tracker RTL.
module tb_top;

    localparam int VBITS = 24;
    localparam int TBITS = 48;

    typedef bit [VBITS-1:0] value_t;
    typedef bit [TBITS-1:0] stamp_t;
    typedef bit [wmt_pkg::WINDOW_BITS-1:0] window_t;

    typedef struct packed {
        value_t value;
        stamp_t stamp;
    } best_t;

    // Mirror of the three slots; predicts the best slot after each accepted sample.
    class min_window_board;
        value_t  slot_val[wmt_pkg::SLOT_COUNT];
        stamp_t  slot_tm[wmt_pkg::SLOT_COUNT];
        bit      primed;
        window_t window;
        best_t   expected_best[$];
        int      mismatches;

        function new();
            foreach (slot_val[s])
            begin
                slot_val[s] = '0;
                slot_tm[s]  = '0;
            end
            primed     = 1'b0;
            window     = wmt_pkg::WINDOW_RESET;
            mismatches = 0;
        endfunction

        function void set_window(window_t w);
            window = w;
        endfunction

        function int pending();
            return expected_best.size();
        endfunction

        // Modular compare: a is no worse than b when a - b is zero or negative.
        function bit value_le(value_t a, value_t b);
            value_t d;
            d = a - b;
            return (d == '0) || d[VBITS-1];
        endfunction

        // A slot has aged out when the wrapped age is strictly above the limit.
        function bit aged_out(int s, stamp_t now, window_t limit);
            stamp_t d;
            d = now - slot_tm[s];
            return d > stamp_t'(limit);
        endfunction

        function void place(int s, value_t v, stamp_t t);
            slot_val[s] = v;
            slot_tm[s]  = t;
        endfunction

        function void note_sample(value_t v, stamp_t t);
            best_t want;
            if (!primed || value_le(v, slot_val[wmt_pkg::SLOT_BEST])
                || aged_out(wmt_pkg::SLOT_THIRD, t, window))
            begin
                // First sample, new best, or the whole window went stale.
                for (int s = 0; s < wmt_pkg::SLOT_COUNT; s++)
                    place(s, v, t);
                primed = 1'b1;
            end
            else
            begin
                if (value_le(v, slot_val[wmt_pkg::SLOT_SECOND]))
                begin
                    place(wmt_pkg::SLOT_SECOND, v, t);
                    place(wmt_pkg::SLOT_THIRD, v, t);
                end
                else if (value_le(v, slot_val[wmt_pkg::SLOT_THIRD]))
                    place(wmt_pkg::SLOT_THIRD, v, t);

                if (aged_out(wmt_pkg::SLOT_BEST, t, window))
                begin
                    // The best sample left the window; promote the survivors.
                    if (aged_out(wmt_pkg::SLOT_SECOND, t, window))
                    begin
                        place(wmt_pkg::SLOT_BEST, slot_val[wmt_pkg::SLOT_THIRD],
                              slot_tm[wmt_pkg::SLOT_THIRD]);
                        place(wmt_pkg::SLOT_SECOND, v, t);
                    end
                    else
                    begin
                        place(wmt_pkg::SLOT_BEST, slot_val[wmt_pkg::SLOT_SECOND],
                              slot_tm[wmt_pkg::SLOT_SECOND]);
                        place(wmt_pkg::SLOT_SECOND, slot_val[wmt_pkg::SLOT_THIRD],
                              slot_tm[wmt_pkg::SLOT_THIRD]);
                    end
                    place(wmt_pkg::SLOT_THIRD, v, t);
                end
                else if (slot_val[wmt_pkg::SLOT_SECOND] == slot_val[wmt_pkg::SLOT_BEST]
                         && aged_out(wmt_pkg::SLOT_SECOND, t,
                                     window >> wmt_pkg::QUARTER_SHIFT))
                begin
                    place(wmt_pkg::SLOT_SECOND, v, t);
                    place(wmt_pkg::SLOT_THIRD, v, t);
                end
                else if (slot_val[wmt_pkg::SLOT_THIRD] == slot_val[wmt_pkg::SLOT_SECOND]
                         && aged_out(wmt_pkg::SLOT_THIRD, t,
                                     window >> wmt_pkg::HALF_SHIFT))
                    place(wmt_pkg::SLOT_THIRD, v, t);
            end
            want.value = slot_val[wmt_pkg::SLOT_BEST];
            want.stamp = slot_tm[wmt_pkg::SLOT_BEST];
            expected_best.insert(expected_best.size(), want);
        endfunction

        function void check_result(value_t v, stamp_t t);
            best_t want;
            if (expected_best.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value %h time %h", v, t);
            end
            else
            begin
                want = expected_best[0];
                expected_best.delete(0);
                if (want.value != v || want.stamp != t)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("best mismatch: expected value %h time %h, got value %h time %h",
                                 want.value, want.stamp, v, t);
                end
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    cfg_wr_en;
    window_t cfg_wr_data;
    bit      send_quiet;

    min_window_board board;

    wmt_sample_if #(.VALUE_BITS(VBITS), .TIME_BITS(TBITS)) sample_ch ();
    wmt_result_if #(.VALUE_BITS(VBITS), .TIME_BITS(TBITS)) result_ch ();

    windowed_min_tracker #(
        .VALUE_BITS(VBITS),
        .TIME_BITS (TBITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .sample     (sample_ch),
        .result     (result_ch)
    );

    // Free-running clock, period 12.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Offer one sample after a random gap and hold it until the transfer.
    task automatic push_sample(value_t v, stamp_t t);
        int gap;
        bit hit;
        if ($urandom_range(0, 39) == 0)
            send_quiet = !send_quiet;
        gap = send_quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.sample_value <= v;
        sample_ch.sample_time  <= t;
        do
        begin
            @(negedge clk);
            hit = sample_ch.ready;
            @(posedge clk);
        end
        while (!hit);
        board.note_sample(v, t);
    endtask

    // Drain every outstanding result, then allow for the pipeline depth.
    task automatic settle();
        sample_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_window(window_t w);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.set_window(w);
    endtask

    // Mostly forward-moving time with values near a drifting floor; some repeats,
    // wild values and time jumps in either direction.
    task automatic random_phase(window_t w, int count);
        longint unsigned span;
        longint unsigned dt;
        value_t          level;
        stamp_t          t;
        int              pick;
        write_window(w);
        t     = stamp_t'({$urandom, $urandom});
        level = value_t'($urandom);
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
            begin
                if ($urandom_range(0, 7) == 0)
                    span = longint'(w) + longint'(w / 2) + 2;
                else
                    span = longint'(w / 3) + 2;
                dt = {$urandom, $urandom} % span;
                t  = t + stamp_t'(dt);
                if ($urandom_range(0, 3) == 0)
                    level = level + value_t'($urandom_range(0, 400)) - value_t'(200);
                push_sample(level + value_t'($urandom_range(0, 600)), t);
            end
            else if (pick < 92)
                push_sample(level, t);
            else if (pick < 96)
                push_sample(value_t'($urandom), t);
            else
            begin
                t = stamp_t'({$urandom, $urandom});
                push_sample(level, t);
            end
        end
    endtask

    // Result side: random stalls, checked on every transfer.
    initial
    begin
        bit got;
        bit recv_quiet;
        int gap;
        result_ch.ready = 1'b0;
        recv_quiet      = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                recv_quiet = !recv_quiet;
            gap = recv_quiet ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
            begin
                @(negedge clk);
                got = result_ch.valid;
                if (got)
                    board.check_result(result_ch.best_value, result_ch.best_time);
                @(posedge clk);
            end
            while (!got);
        end
    end

    // Main sequence: reset, directed cases, random phases, final verdict.
    initial
    begin
        board                  = new();
        send_quiet             = 1'b0;
        rst_n                  = 1'b0;
        cfg_wr_en              = 1'b0;
        cfg_wr_data            = '0;
        sample_ch.valid        = 1'b0;
        sample_ch.sample_value = '0;
        sample_ch.sample_time  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset window: first sample, plain sample, new best, quarter refresh,
        // half refresh, best expiry with a shift, best and second both expired.
        push_sample(24'd100, 48'd1000);
        push_sample(24'd200, 48'd2000);
        push_sample(24'd50,  48'd3000);
        push_sample(24'd80,  48'd3003000);
        push_sample(24'd90,  48'd8103000);
        push_sample(24'd95,  48'd10003001);
        push_sample(24'd99,  48'd18103001);
        // Modular compare near the top of the value range.
        push_sample(24'hFFFFFF, 48'd18103011);
        push_sample(24'h000000, 48'd18103021);
        push_sample(24'h800000, 48'd18103031);
        // Time going backwards, then wrapping past the top of the range.
        push_sample(24'd16, 48'd18103000);
        push_sample(24'd5,  48'hFFFF_FFFF_FFF0);
        push_sample(24'd7,  48'h0000_0000_0005);
        push_sample(24'd5,  48'h0000_0000_0006);

        // Zero window: any positive age expires.
        write_window('0);
        push_sample(24'd9,  48'd100);
        push_sample(24'd12, 48'd100);
        push_sample(24'd12, 48'd101);

        // Largest window: age equal to the window holds, one more expires.
        write_window('1);
        push_sample(24'd20, 48'h0);
        push_sample(24'd30, 48'h0000_FFFF_FFFF);
        push_sample(24'd40, 48'h0001_0000_0000);

        random_phase(32'd1, 200);
        random_phase(32'd3, 200);
        random_phase(32'd40, 200);
        random_phase(32'd1000, 200);
        random_phase(32'd100000, 200);
        random_phase(wmt_pkg::WINDOW_RESET, 200);
        random_phase(window_t'($urandom), 200);
        random_phase('0, 200);
        random_phase('1, 200);

        settle();
        repeat (6) @(posedge clk);
        if (board.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
hdl/wmt_pkg.sv
hdl/wmt_stream_if.sv
hdl/wmt_slots.sv
hdl/windowed_min_tracker.sv
tb/sv/tb_top.sv
